>>> rtl/scan_curvature_window_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan curvature window
// Each macro expands to a labeled concurrent assertion, or to nothing when
// SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SCAN_CURVATURE_WINDOW_ASSERT_SVH
`define SCAN_CURVATURE_WINDOW_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SCW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scw: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define SCW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scw: next-cycle check failed");
`else
`define SCW_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/scw_pkg.sv
// ----------------------------------------------------------------------------
// scw_pkg
// Shared widths, constants and types of the scan curvature window.
// ----------------------------------------------------------------------------
package scw_pkg;

   localparam int AXES      = 3;
   localparam int LINE_W    = 4;
   localparam int IDX_OUT_W = 16;
   localparam int CURV_W    = 45;
   localparam int THR_W     = 48;

   localparam logic [THR_W-1:0]  THR_RESET = 48'd104858;
   localparam logic [CURV_W-1:0] CURV_MAX  = {CURV_W{1'b1}};

   // Side information that travels with one result through the arithmetic.
   typedef struct packed {
      logic                 full;
      logic                 line_ok;
      logic                 last;
      logic [IDX_OUT_W-1:0] point_index;
   } scw_flags_type;

endpackage

>>> rtl/scw_req_if.sv
// ----------------------------------------------------------------------------
// scw_req_if
// Point request channel: valid/ready handshake with one lidar point.
// ----------------------------------------------------------------------------
interface scw_req_if #(
   parameter int COORD_BITS = 18
);
   logic                              valid;
   logic                              ready;
   logic signed [COORD_BITS-1:0]      x_pos;
   logic signed [COORD_BITS-1:0]      y_pos;
   logic signed [COORD_BITS-1:0]      z_pos;
   logic [scw_pkg::LINE_W-1:0]        scan_line;
   logic                              frame_end;

   modport source (output valid, x_pos, y_pos, z_pos, scan_line, frame_end, input ready);
   modport sink   (input valid, x_pos, y_pos, z_pos, scan_line, frame_end, output ready);
endinterface

>>> rtl/scw_rsp_if.sv
// ----------------------------------------------------------------------------
// scw_rsp_if
// Result channel: valid/ready handshake with one curvature result.
// ----------------------------------------------------------------------------
interface scw_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [scw_pkg::IDX_OUT_W-1:0]     point_index;
   logic [scw_pkg::CURV_W-1:0]        curvature;
   logic                              curvature_valid;
   logic                              above_threshold;
   logic                              last_of_frame;

   modport source (output valid, point_index, curvature, curvature_valid, above_threshold,
                   last_of_frame, input ready);
   modport sink   (input valid, point_index, curvature, curvature_valid, above_threshold,
                   last_of_frame, output ready);
endinterface

>>> rtl/scw_cell.sv
// ----------------------------------------------------------------------------
// scw_cell
// One slot of the point window: holds a point, passes it on at each shift and
// compares its scan line with the center's.
// ----------------------------------------------------------------------------
module scw_cell #(
   parameter int COORD_BITS = 18,
   parameter int IDX_W      = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            shift,
   input  logic                            clear,
   input  logic                            in_occ,
   input  logic signed [COORD_BITS-1:0]    in_pos [scw_pkg::AXES],
   input  logic [scw_pkg::LINE_W-1:0]      in_line,
   input  logic [IDX_W-1:0]                in_idx,
   input  logic [scw_pkg::LINE_W-1:0]      centre_line,
   output logic                            out_occ,
   output logic signed [COORD_BITS-1:0]    out_pos [scw_pkg::AXES],
   output logic [scw_pkg::LINE_W-1:0]      out_line,
   output logic [IDX_W-1:0]                out_idx,
   output logic                            match
);

   logic                            occ_ff, occ_in;
   logic signed [COORD_BITS-1:0]    pos_ff [scw_pkg::AXES];
   logic [scw_pkg::LINE_W-1:0]      line_ff;
   logic [IDX_W-1:0]                idx_ff;

   // A clear empties the slot while the incoming point moves in behind it.
   assign occ_in = shift ? (in_occ && !clear) : occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         pos_ff  <= in_pos;
         line_ff <= in_line;
         idx_ff  <= in_idx;
      end
   end

   assign out_occ  = occ_ff;
   assign out_pos  = pos_ff;
   assign out_line = line_ff;
   assign out_idx  = idx_ff;
   assign match    = occ_ff && (line_ff == centre_line);

endmodule

>>> rtl/scw_sq.sv
// ----------------------------------------------------------------------------
// scw_sq
// Squares the three axis differences, sums and saturates them, applies the
// threshold and holds the result in the output register.
// ----------------------------------------------------------------------------
module scw_sq #(
   parameter int DIFF_W = 23
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [DIFF_W-1:0]      in_diff [scw_pkg::AXES],
   input  scw_pkg::scw_flags_type        in_flags,
   input  logic [scw_pkg::THR_W-1:0]     threshold,
   scw_rsp_if.source                     rsp_ch
);

   localparam int MW   = DIFF_W - 1;
   localparam int SQW  = 2 * MW;
   localparam int QW   = SQW + 2;
   localparam int CMPW = (QW > scw_pkg::THR_W) ? QW : scw_pkg::THR_W;
   localparam logic [CMPW-1:0] SAT_LIM = CMPW'(scw_pkg::CURV_MAX);

   logic                           s2_vld_ff, s2_vld_in;
   logic [SQW-1:0]                 sq_ff [scw_pkg::AXES];
   logic [SQW-1:0]                 sq_in [scw_pkg::AXES];
   logic signed [2*DIFF_W-1:0]     prod [scw_pkg::AXES];
   scw_pkg::scw_flags_type         s2_flags_ff;
   logic                           s2_rdy, s3_rdy;

   logic                           rsp_vld_ff, rsp_vld_in;
   logic [scw_pkg::IDX_OUT_W-1:0]  idx_ff;
   logic [scw_pkg::CURV_W-1:0]     curv_ff, curv_in;
   logic                           cvalid_ff, cvalid_in;
   logic                           above_ff, above_in;
   logic                           last_ff;

   logic [CMPW-1:0]                total;
   logic [CMPW-1:0]                thr_ext;
   logic                           sat;

   assign s3_rdy   = !rsp_vld_ff || rsp_ch.ready;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign in_ready = s2_rdy;

   // The square of a signed value is never negative, so its low bits suffice.
   always_comb begin
      for (int a = 0; a < scw_pkg::AXES; a++) begin
         prod[a]  = (2*DIFF_W)'(in_diff[a]) * (2*DIFF_W)'(in_diff[a]);
         sq_in[a] = prod[a][SQW-1:0];
      end
   end

   assign s2_vld_in  = s2_rdy ? in_valid : s2_vld_ff;
   assign rsp_vld_in = s3_rdy ? s2_vld_ff : rsp_vld_ff;

   always_comb begin
      total   = CMPW'(sq_ff[0]) + CMPW'(sq_ff[1]) + CMPW'(sq_ff[2]);
      thr_ext = CMPW'(threshold);
      sat     = total > SAT_LIM;
      curv_in = '0;
      above_in = 1'b0;
      if (s2_flags_ff.full) begin
         curv_in  = sat ? scw_pkg::CURV_MAX : total[scw_pkg::CURV_W-1:0];
         above_in = sat ? (SAT_LIM > thr_ext) : (total > thr_ext);
      end
      cvalid_in = s2_flags_ff.full && s2_flags_ff.line_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy && in_valid) begin
         sq_ff       <= sq_in;
         s2_flags_ff <= in_flags;
      end
      if (s3_rdy && s2_vld_ff) begin
         idx_ff    <= s2_flags_ff.point_index;
         curv_ff   <= curv_in;
         cvalid_ff <= cvalid_in;
         above_ff  <= above_in;
         last_ff   <= s2_flags_ff.last;
      end
   end

   assign rsp_ch.valid           = rsp_vld_ff;
   assign rsp_ch.point_index     = idx_ff;
   assign rsp_ch.curvature       = curv_ff;
   assign rsp_ch.curvature_valid = cvalid_ff;
   assign rsp_ch.above_threshold = above_ff;
   assign rsp_ch.last_of_frame   = last_ff;

endmodule

>>> rtl/scan_curvature_window.sv
// ----------------------------------------------------------------------------
// scan_curvature_window
// Throughput: one point request per cycle unless the result path stalls; a
// request with frame_end set is followed by HALF_WINDOW flush shifts in which
// no request is taken. The result for the point shifted into the center slot
// passes the difference, square and output registers. Synchronous active-high
// reset empties the window, zeroes the frame counter and restores the threshold.
// ----------------------------------------------------------------------------
`include "scan_curvature_window_assert.svh"

module scan_curvature_window #(
   parameter int HALF_WINDOW      = 5,
   parameter int MAX_FRAME_POINTS = 65536,
   parameter int LINE_COUNT       = 16,
   parameter int COORD_BITS       = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   scw_req_if.sink                       req_ch,
   scw_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [scw_pkg::THR_W-1:0]     csr_wr_data
);

   // Window geometry and derived widths. The running sum covers the whole
   // window; the difference is the sum minus WIN times the center point,
   // which equals the neighbor sum minus 2*HALF_WINDOW times the center.
   localparam int WIN   = 2 * HALF_WINDOW + 1;
   localparam int LOGW  = $clog2(WIN);
   localparam int SW    = COORD_BITS + LOGW;
   localparam int DW    = SW + 1;
   localparam int IDX_W = $clog2(MAX_FRAME_POINTS);
   localparam int FW    = $clog2(HALF_WINDOW + 1);
   localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(MAX_FRAME_POINTS - 1);
   localparam logic signed [DW-1:0]  WIN_MUL  = DW'(WIN);

   // Handshake and flow control.
   logic                           acc_req;
   logic                           w_free;
   logic                           shift_w;
   logic                           s1_rdy;
   logic                           sq_rdy;

   // Window control state.
   logic [FW-1:0]                  flush_cnt_ff, flush_cnt_in;
   logic                           clear_ff, clear_in;
   logic                           w_pend_ff, w_pend_in;
   logic                           w_last_ff, w_last_in;
   logic [IDX_W-1:0]               frame_cnt_ff, frame_cnt_in;
   logic [scw_pkg::THR_W-1:0]      thr_ff, thr_in;

   // Running window sums, one per axis.
   logic signed [SW-1:0]           sum_ff [scw_pkg::AXES];
   logic signed [SW-1:0]           sum_in [scw_pkg::AXES];
   logic signed [SW-1:0]           add_ext [scw_pkg::AXES];
   logic signed [SW-1:0]           sub_ext [scw_pkg::AXES];

   // The chain of window cells; cell 0 holds the newest point.
   logic signed [COORD_BITS-1:0]   head_pos [scw_pkg::AXES];
   logic [WIN-1:0]                 cell_occ;
   logic [WIN-1:0]                 cell_match;
   logic signed [COORD_BITS-1:0]   cell_pos [WIN][scw_pkg::AXES];
   logic [scw_pkg::LINE_W-1:0]     cell_line [WIN];
   logic [IDX_W-1:0]               cell_idx [WIN];

   // Difference stage feeding the square unit.
   logic                           s1_vld_ff, s1_vld_in;
   logic signed [DW-1:0]           d_ff [scw_pkg::AXES];
   logic signed [DW-1:0]           d_in [scw_pkg::AXES];
   logic signed [DW-1:0]           sum_ext [scw_pkg::AXES];
   logic signed [DW-1:0]           ctr_ext [scw_pkg::AXES];
   scw_pkg::scw_flags_type         s1_flags_ff, flags_in;
   logic [IDX_W+scw_pkg::IDX_OUT_W-1:0] idx_pad;

   // ------------------------------------------------------------------------
   // Flow control. The window may shift once the result it is holding (if
   // any) can move on to the difference stage. During a flush the window
   // shifts in empty slots on its own and requests are held off.
   // ------------------------------------------------------------------------
   assign w_free       = !w_pend_ff || s1_rdy;
   assign req_ch.ready = w_free && (flush_cnt_ff == '0);
   assign acc_req      = req_ch.valid && req_ch.ready;
   assign shift_w      = w_free && (acc_req || (flush_cnt_ff != '0));

   always_comb begin
      flush_cnt_in = flush_cnt_ff;
      clear_in     = clear_ff;
      frame_cnt_in = frame_cnt_ff;
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;

      if (acc_req) begin
         // A new point consumes any pending clear of the previous frame.
         clear_in = 1'b0;
         if (req_ch.frame_end) begin
            flush_cnt_in = FW'(HALF_WINDOW);
            frame_cnt_in = '0;
         end else begin
            frame_cnt_in = (frame_cnt_ff == IDX_LAST) ? '0 : frame_cnt_ff + 1'b1;
         end
      end else if (shift_w) begin
         // Flush step. After the last one the old frame must leave the window
         // before the next frame's first point sees it.
         flush_cnt_in = flush_cnt_ff - 1'b1;
         if (flush_cnt_ff == FW'(1)) begin
            clear_in = 1'b1;
         end
      end

      // After a shift the point just moved into the center slot owes a result;
      // without a shift a held result leaves as soon as the next stage takes it.
      if (shift_w) begin
         w_pend_in = cell_occ[HALF_WINDOW-1] && !clear_ff;
         w_last_in = !acc_req && (flush_cnt_ff == FW'(1));
      end else begin
         w_pend_in = w_free ? 1'b0 : w_pend_ff;
         w_last_in = w_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_cnt_ff <= '0;
         clear_ff     <= 1'b0;
         w_pend_ff    <= 1'b0;
         w_last_ff    <= 1'b0;
         frame_cnt_ff <= '0;
         thr_ff       <= scw_pkg::THR_RESET;
      end else begin
         flush_cnt_ff <= flush_cnt_in;
         clear_ff     <= clear_in;
         w_pend_ff    <= w_pend_in;
         w_last_ff    <= w_last_in;
         frame_cnt_ff <= frame_cnt_in;
         thr_ff       <= thr_in;
      end
   end

   // ------------------------------------------------------------------------
   // Window cells. A flush step shifts in an empty slot with zero coordinates.
   // ------------------------------------------------------------------------
   assign head_pos[0] = acc_req ? req_ch.x_pos : '0;
   assign head_pos[1] = acc_req ? req_ch.y_pos : '0;
   assign head_pos[2] = acc_req ? req_ch.z_pos : '0;

   for (genvar k = 0; k < WIN; k++) begin : g_cell
      if (k == 0) begin : g_head
         scw_cell #(
            .COORD_BITS (COORD_BITS),
            .IDX_W      (IDX_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift_w),
            .clear       (1'b0),
            .in_occ      (acc_req),
            .in_pos      (head_pos),
            .in_line     (req_ch.scan_line),
            .in_idx      (frame_cnt_ff),
            .centre_line (cell_line[HALF_WINDOW]),
            .out_occ     (cell_occ[k]),
            .out_pos     (cell_pos[k]),
            .out_line    (cell_line[k]),
            .out_idx     (cell_idx[k]),
            .match       (cell_match[k])
         );
      end else begin : g_body
         scw_cell #(
            .COORD_BITS (COORD_BITS),
            .IDX_W      (IDX_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (shift_w),
            .clear       (clear_ff),
            .in_occ      (cell_occ[k-1]),
            .in_pos      (cell_pos[k-1]),
            .in_line     (cell_line[k-1]),
            .in_idx      (cell_idx[k-1]),
            .centre_line (cell_line[HALF_WINDOW]),
            .out_occ     (cell_occ[k]),
            .out_pos     (cell_pos[k]),
            .out_line    (cell_line[k]),
            .out_idx     (cell_idx[k]),
            .match       (cell_match[k])
         );
      end
   end

   // ------------------------------------------------------------------------
   // Running sums. Each shift adds the entering point and drops the point
   // that leaves the oldest slot; a clear restarts the sum at the new point.
   // ------------------------------------------------------------------------
   always_comb begin
      for (int a = 0; a < scw_pkg::AXES; a++) begin
         add_ext[a] = SW'(head_pos[a]);
         sub_ext[a] = cell_occ[WIN-1] ? SW'(cell_pos[WIN-1][a]) : '0;
         if (!shift_w) begin
            sum_in[a] = sum_ff[a];
         end else if (clear_ff) begin
            sum_in[a] = add_ext[a];
         end else begin
            sum_in[a] = sum_ff[a] + add_ext[a] - sub_ext[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < scw_pkg::AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else begin
         sum_ff <= sum_in;
      end
   end

   // ------------------------------------------------------------------------
   // Difference stage: axis differences and the window flags of the center.
   // The window is full when every slot holds a point of this frame; the line
   // check needs every slot on the center's ring and that ring in range.
   // ------------------------------------------------------------------------
   assign idx_pad = {{scw_pkg::IDX_OUT_W{1'b0}}, cell_idx[HALF_WINDOW]};

   always_comb begin
      for (int a = 0; a < scw_pkg::AXES; a++) begin
         sum_ext[a] = DW'(sum_ff[a]);
         ctr_ext[a] = DW'(cell_pos[HALF_WINDOW][a]);
         d_in[a]    = sum_ext[a] - WIN_MUL * ctr_ext[a];
      end
      flags_in.full        = &cell_occ;
      flags_in.line_ok     = (&cell_match) && (32'(cell_line[HALF_WINDOW]) < LINE_COUNT);
      flags_in.last        = w_last_ff;
      flags_in.point_index = idx_pad[scw_pkg::IDX_OUT_W-1:0];
   end

   assign s1_rdy    = !s1_vld_ff || sq_rdy;
   assign s1_vld_in = s1_rdy ? w_pend_ff : s1_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy && w_pend_ff) begin
         d_ff        <= d_in;
         s1_flags_ff <= flags_in;
      end
   end

   // Squares, saturated sum, threshold and the output register.
   scw_sq #(
      .DIFF_W (DW)
   ) u_sq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_vld_ff),
      .in_ready  (sq_rdy),
      .in_diff   (d_ff),
      .in_flags  (s1_flags_ff),
      .threshold (thr_ff),
      .rsp_ch    (rsp_ch)
   );

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------
   `SCW_ASSERT_NXT(a_flush_start, clock, reset, acc_req && req_ch.frame_end,
                   flush_cnt_ff == FW'(HALF_WINDOW))
   `SCW_ASSERT_NXT(a_pend_held, clock, reset, w_pend_ff && !s1_rdy, w_pend_ff)
   `SCW_ASSERT_IMP(a_clear_idle, clock, reset, clear_ff, flush_cnt_ff == '0)
   `SCW_ASSERT_IMP(a_above_nonzero, clock, reset, rsp_ch.valid && rsp_ch.above_threshold,
                   rsp_ch.curvature != '0)

endmodule

>>> tb/sv/scan_curvature_window_tb.sv
// ----------------------------------------------------------------------------
// scan_curvature_window_tb
// Self-checking testbench for the scan curvature window. Lidar points are sent
// as requests in frames, and a local predictor of the 11-point window works out
// the curvature result of every center point. Each result that leaves the block
// is compared field by field with the oldest prediction. Both channels idle at
// random, and the threshold register is rewritten between frames.
// ----------------------------------------------------------------------------
module scan_curvature_window_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Shared widths of the block.
   localparam int AXES      = scw_pkg::AXES;
   localparam int LINE_W    = scw_pkg::LINE_W;
   localparam int IDX_OUT_W = scw_pkg::IDX_OUT_W;
   localparam int CURV_W    = scw_pkg::CURV_W;
   localparam int THR_W     = scw_pkg::THR_W;

   // Geometry of the block under test, at its default parameters.
   localparam int HALF       = 5;
   localparam int SPAN       = 2 * HALF + 1;
   localparam int COORD_W    = 18;
   localparam int COORD_SPAN = 1 << COORD_W;

   // Run control.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 12;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_ITEMS   = 24;

   localparam logic [THR_W-1:0] THR_TOP = {THR_W{1'b1}};

   typedef struct packed {
      logic signed [COORD_W-1:0] x_pos;
      logic signed [COORD_W-1:0] y_pos;
      logic signed [COORD_W-1:0] z_pos;
      logic [LINE_W-1:0]         scan_line;
      logic                      frame_end;
   } point_type;

   typedef struct packed {
      logic [IDX_OUT_W-1:0] point_index;
      logic [CURV_W-1:0]    curvature;
      logic                 curvature_valid;
      logic                 above_threshold;
      logic                 last_of_frame;
   } curv_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [THR_W-1:0]  csr_wr_data;

   scw_req_if #(.COORD_BITS(COORD_W)) req_ch ();
   scw_rsp_if                         rsp_ch ();

   scan_curvature_window u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor state: a copy of the point window, the frame counter and the
   // threshold. Slot 0 holds the newest point and slot HALF is the center.
   // ------------------------------------------------------------------------
   logic signed [COORD_W-1:0] win_pos [AXES][SPAN];
   logic [LINE_W-1:0]         win_line [SPAN];
   logic [SPAN-1:0]           win_occupied;
   logic [IDX_OUT_W-1:0]      frame_count;
   logic [THR_W-1:0]          thr_level;

   curv_result_type pending_curvatures [$];

   int  fail_count  = 0;
   int  idle_cycles = 0;
   bit  gaps_on     = 1'b0;
   bit  stalls_on   = 1'b0;
   int  stall_left  = 0;

   function automatic void clear_window();
      for (int s = 0; s < SPAN; s++) begin
         for (int a = 0; a < AXES; a++) begin
            win_pos[a][s] = '0;
         end
         win_line[s] = '0;
      end
      win_occupied = '0;
      frame_count  = '0;
   endfunction

   // Moves every point one slot older. An empty slot enters during the flush.
   function automatic void shift_window(input logic occ, input point_type p);
      for (int s = SPAN - 1; s > 0; s--) begin
         for (int a = 0; a < AXES; a++) begin
            win_pos[a][s] = win_pos[a][s-1];
         end
         win_line[s] = win_line[s-1];
      end
      win_pos[0][0] = occ ? p.x_pos : '0;
      win_pos[1][0] = occ ? p.y_pos : '0;
      win_pos[2][0] = occ ? p.z_pos : '0;
      win_line[0]   = occ ? p.scan_line : '0;
      win_occupied  = {win_occupied[SPAN-2:0], occ};
   endfunction

   // Square of (sum of the ten neighbors minus ten times the center) on one axis.
   function automatic longint unsigned axis_square(input int a);
      longint d;
      d = 0;
      for (int s = 0; s < SPAN; s++) begin
         if (s != HALF) begin
            d += longint'(win_pos[a][s]);
         end
      end
      d -= longint'(2 * HALF) * longint'(win_pos[a][HALF]);
      if (d < 0) begin
         d = -d;
      end
      return longint'(d) * longint'(d);
   endfunction

   // Result for the point now in the center slot, which entered lag points
   // before the current frame count.
   function automatic curv_result_type center_result(input int lag, input logic last_flag);
      curv_result_type r;
      longint unsigned total;
      logic            full;
      full  = &win_occupied;
      total = 0;
      r.curvature_valid = full;
      if (full) begin
         // The running total saturates at the top of the curvature field.
         total = axis_square(0) + axis_square(1);
         if (total > scw_pkg::CURV_MAX) begin
            total = scw_pkg::CURV_MAX;
         end
         total += axis_square(2);
         if (total > scw_pkg::CURV_MAX) begin
            total = scw_pkg::CURV_MAX;
         end
         // Any neighbor on another ring clears the valid flag.
         for (int s = 0; s < SPAN; s++) begin
            if (win_line[s] != win_line[HALF]) begin
               r.curvature_valid = 1'b0;
            end
         end
      end
      r.point_index     = frame_count - IDX_OUT_W'(1 + lag);
      r.curvature       = total[CURV_W-1:0];
      r.above_threshold = full && (total > thr_level);
      r.last_of_frame   = last_flag;
      return r;
   endfunction

   // Appends one predicted result behind the ones already waiting.
   function automatic void queue_expected(input curv_result_type r);
      pending_curvatures.insert(pending_curvatures.size(), r);
   endfunction

   // Works out every result that one accepted point request causes.
   function automatic void predict_curvatures(input point_type p);
      shift_window(1'b1, p);
      frame_count++;
      if (win_occupied[HALF]) begin
         queue_expected(center_result(HALF, 1'b0));
      end
      if (p.frame_end) begin
         // The flush pushes empty slots until the last point of the frame has
         // reached the center, then the next frame starts with an empty window.
         for (int b = 1; b <= HALF; b++) begin
            shift_window(1'b0, '0);
            if (win_occupied[HALF]) begin
               queue_expected(center_result(HALF - b, b == HALF));
            end
         end
         clear_window();
      end
   endfunction

   function automatic void check_result();
      curv_result_type got;
      curv_result_type want;
      got.point_index     = rsp_ch.point_index;
      got.curvature       = rsp_ch.curvature;
      got.curvature_valid = rsp_ch.curvature_valid;
      got.above_threshold = rsp_ch.above_threshold;
      got.last_of_frame   = rsp_ch.last_of_frame;
      if (pending_curvatures.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: result with nothing pending: index %0d curvature %0d",
                     $realtime, got.point_index, got.curvature);
         end
         return;
      end
      want = pending_curvatures.pop_front();
      if (got.point_index !== want.point_index || got.curvature !== want.curvature ||
          got.curvature_valid !== want.curvature_valid ||
          got.above_threshold !== want.above_threshold ||
          got.last_of_frame !== want.last_of_frame) begin
         fail_count++;
         if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: expected idx %0d curv %0d valid %0b above %0b last %0b",
                     $realtime, want.point_index, want.curvature, want.curvature_valid,
                     want.above_threshold, want.last_of_frame);
            $display("%0t:   actual idx %0d curv %0d valid %0b above %0b last %0b",
                     $realtime, got.point_index, got.curvature, got.curvature_valid,
                     got.above_threshold, got.last_of_frame);
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor. Both channels are sampled at the rising edge, before any of the
   // nonblocking updates of that edge land, so each handshake is seen exactly
   // as the block saw it. The idle counter feeds the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      point_type p;
      logic      took;
      took = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         p.x_pos     = req_ch.x_pos;
         p.y_pos     = req_ch.y_pos;
         p.z_pos     = req_ch.z_pos;
         p.scan_line = req_ch.scan_line;
         p.frame_end = req_ch.frame_end;
         predict_curvatures(p);
         took = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         check_result();
         took = 1'b1;
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 3);
      end else if (r < 93) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 40);
   endfunction

   // The result side stalls at random while stalls are enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left   <= stall_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         stall_left   <= idle_len() - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // A run that stops moving on both channels has hung.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic point_type make_point(input int x, input int y, input int z,
                                            input int ring, input logic fend);
      point_type p;
      p.x_pos     = x[COORD_W-1:0];
      p.y_pos     = y[COORD_W-1:0];
      p.z_pos     = z[COORD_W-1:0];
      p.scan_line = ring[LINE_W-1:0];
      p.frame_end = fend;
      return p;
   endfunction

   // Offers one point request and returns at the edge that accepts it, or after
   // the idle gap that may follow it. Valid stays high when the next request
   // follows at once, so it is never lowered and raised within one time step.
   task automatic send_point(input point_type p);
      req_ch.valid     <= 1'b1;
      req_ch.x_pos     <= p.x_pos;
      req_ch.y_pos     <= p.y_pos;
      req_ch.z_pos     <= p.z_pos;
      req_ch.scan_line <= p.scan_line;
      req_ch.frame_end <= p.frame_end;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat (idle_len()) @(posedge clock);
      end
   endtask

   // Waits until every predicted result has come back, then lets the output
   // pipeline run dry before anything else happens.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_curvatures.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      thr_level    = value;
   endtask

   // One frame of random points. A tame frame follows a straight line with a
   // little noise, so curvature lands near useful thresholds; a wild frame uses
   // the full coordinate range. Rings advance now and then, and a stray ring
   // number shows up once in a while.
   task automatic send_frame(input int n_points, input bit wild);
      int                base [AXES];
      int                step [AXES];
      int                c [AXES];
      int                noise;
      logic [LINE_W-1:0] ring;
      for (int a = 0; a < AXES; a++) begin
         base[a] = int'($urandom_range(0, COORD_SPAN - 1)) - COORD_SPAN / 2;
         step[a] = int'($urandom_range(0, 400)) - 200;
      end
      case ($urandom_range(0, 3))
         0: noise = 0;
         1: noise = 16;
         2: noise = 128;
         default: noise = 600;
      endcase
      ring = LINE_W'($urandom_range(0, 15));
      for (int i = 0; i < n_points; i++) begin
         for (int a = 0; a < AXES; a++) begin
            if (wild || $urandom_range(0, 19) == 0) begin
               c[a] = int'($urandom_range(0, COORD_SPAN - 1)) - COORD_SPAN / 2;
            end else begin
               c[a] = base[a] + i * step[a] + int'($urandom_range(0, 2 * noise)) - noise;
            end
         end
         if ($urandom_range(0, 11) == 0) begin
            ring++;
         end
         send_point(make_point(c[0], c[1], c[2],
                               ($urandom_range(0, 40) == 0) ? int'($urandom_range(0, 15))
                                                            : int'(ring),
                               i == n_points - 1));
      end
   endtask

   // A flat frame with a single bump of one unit in x at the center point; its
   // curvature is exactly 100.
   task automatic send_bump_frame();
      for (int i = 0; i < SPAN; i++) begin
         send_point(make_point((i == HALF) ? 1 : 0, 0, 0, 2, i == SPAN - 1));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Frames shorter than the window: a one-point frame and a two-point frame.
   // Every result is an edge result, and the flush alone produces them.
   task automatic test_short_frames();
      send_point(make_point(0, 0, 0, 0, 1'b1));
      send_point(make_point(-5, 7, 1, 9, 1'b0));
      send_point(make_point(3, -2, 0, 9, 1'b1));
   endtask

   // Coordinate extremes on the top ring: the center sits at one end of the
   // range and all ten neighbors at the other, which gives the largest
   // curvature the block can see.
   task automatic test_extreme_coords();
      int lo;
      int hi;
      lo = -(COORD_SPAN / 2);
      hi = COORD_SPAN / 2 - 1;
      for (int i = 0; i < SPAN; i++) begin
         if (i == HALF) begin
            send_point(make_point(lo, hi, lo, 15, 1'b0));
         end else begin
            send_point(make_point(hi, lo, hi, 15, i == SPAN - 1));
         end
      end
   endtask

   // The ring changes right at the center point, so its curvature is computed
   // but not marked valid.
   task automatic test_line_change();
      for (int i = 0; i < SPAN; i++) begin
         send_point(make_point(100 + 3 * i, -40 + int'($urandom_range(0, 20)),
                               2000 - i, (i < HALF) ? 3 : 4, i == SPAN - 1));
      end
   endtask

   // Threshold extremes and the strict comparison: a curvature equal to the
   // threshold is not above it, one more than the threshold is.
   task automatic test_threshold_levels();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      write_threshold('0);
      for (int i = 0; i < 12; i++) begin
         send_point(make_point(777, -777, 12, 6, i == 11));
      end
      send_frame(14, 1'b0);
      write_threshold(THR_TOP);
      send_frame(14, 1'b1);
      write_threshold(THR_W'(100));
      send_bump_frame();
      write_threshold(THR_W'(99));
      send_bump_frame();
   endtask

   // Random frames, mostly long enough to fill the window, with random
   // thresholds in between and idling switched on and off per frame.
   task automatic test_random_frames();
      int          sent;
      int          n;
      logic [63:0] wide;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: write_threshold('0);
               1: write_threshold(THR_TOP);
               2: write_threshold(THR_W'($urandom_range(0, 4000000)));
               default: begin
                  wide = {$urandom(), $urandom()};
                  write_threshold(wide[THR_W-1:0]);
               end
            endcase
         end
         gaps_on   = $urandom_range(0, 3) != 0;
         stalls_on = $urandom_range(0, 3) != 0;
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 30);
         send_frame(n, $urandom_range(0, 3) == 0);
         sent += n;
      end
      write_threshold(scw_pkg::THR_RESET);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence. Every input is driven from time zero; reset is held at
   // the start and never asserted again.
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.x_pos     <= '0;
      req_ch.y_pos     <= '0;
      req_ch.z_pos     <= '0;
      req_ch.scan_line <= '0;
      req_ch.frame_end <= 1'b0;
      csr_wr_en        <= 1'b0;
      csr_wr_data      <= '0;
      clear_window();
      thr_level = scw_pkg::THR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The directed part runs at the reset threshold without idling first.
      test_short_frames();
      test_extreme_coords();
      test_line_change();
      test_threshold_levels();
      test_random_frames();

      settle();
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/scw_pkg.sv
rtl/scw_req_if.sv
rtl/scw_rsp_if.sv
rtl/scw_cell.sv
rtl/scw_sq.sv
rtl/scan_curvature_window.sv
tb/sv/scan_curvature_window_tb.sv
